/* hdl/earn_pkg.sv */
package earn_pkg;

  localparam int IN_BITS        = 24;
  localparam int CFG_BITS       = 24;
  localparam int CFG_IDX_BITS   = 3;
  localparam int FRAC_BITS      = 17;
  localparam int Q_BITS         = 16;
  localparam int TDATA_IN_BITS  = 24;
  localparam int TDATA_OUT_BITS = 24;
  localparam int READING_BITS_DEF = 24;

  localparam logic [FRAC_BITS-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MANUAL_RANGE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_BITS    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MANUAL_MIN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MANUAL_MAX   = 3'd5;

  localparam logic [CFG_BITS-1:0] MASK_RESET       = 24'h00FFFF;
  localparam logic [CFG_BITS-1:0] MANUAL_MAX_RESET = 24'h00FFFF;

endpackage

/* hdl/encoder_auto_range_normalizer_core.sv */
// An input transaction passes through states LOAD and DONE when disabled, LOAD, CHECK
// and DONE when no division is needed, and LOAD, CHECK, DIV and DONE when the 16-step
// restoring divider runs (one quotient bit per cycle). DONE waits out any output stall;
// the block takes no new input until the current result sits in the output register.
// Reset (rst_n low, synchronous) clears control state, loads register defaults
// and sets the tracked range to min = mask, max = 0.
module encoder_auto_range_normalizer_core
  import earn_pkg::*;
#(
  parameter int READING_BITS = READING_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [TDATA_IN_BITS-1:0]  in_tdata,   // [23:0] raw_reading
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [TDATA_OUT_BITS-1:0] out_tdata,  // [16:0] fraction, [23:17] zero
  output logic                      out_tuser,  // [0] range_ok
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_wdata
);

  localparam int DW = (READING_BITS < IN_BITS) ? READING_BITS : IN_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic                 enable_r, enable_nxt;
  logic                 invert_r, invert_nxt;
  logic                 manual_r, manual_nxt;
  logic [CFG_BITS-1:0]  mask_r, mask_nxt;
  logic [CFG_BITS-1:0]  mmin_r, mmin_nxt;
  logic [CFG_BITS-1:0]  mmax_r, mmax_nxt;
  logic [DW-1:0]        tmin_r, tmin_nxt;
  logic [DW-1:0]        tmax_r, tmax_nxt;
  logic [DW-1:0]        v_r, v_nxt;
  logic [DW-1:0]        lo_r, lo_nxt;
  logic [DW-1:0]        hi_r, hi_nxt;
  logic [DW-1:0]        den_r, den_nxt;
  logic [DW:0]          rem_r, rem_nxt;
  logic [Q_BITS-1:0]    q_r, q_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FRAC_BITS-1:0] out_frac_r, out_frac_nxt;
  logic                 out_ok_r, out_ok_nxt;

  logic [DW:0]          trial;
  logic [DW:0]          diff;
  logic                 cfg_hit;

  assign trial   = {rem_r[DW-1:0], 1'b0};
  assign diff    = trial - {1'b0, den_r};
  assign cfg_hit = cfg_we && (cfg_index <= REG_MANUAL_MAX);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_OUT_BITS-FRAC_BITS){1'b0}}, out_frac_r};
  assign out_tuser  = out_ok_r;

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    invert_nxt    = invert_r;
    manual_nxt    = manual_r;
    mask_nxt      = mask_r;
    mmin_nxt      = mmin_r;
    mmax_nxt      = mmax_r;
    tmin_nxt      = tmin_r;
    tmax_nxt      = tmax_r;
    v_nxt         = v_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    frac_nxt      = frac_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_frac_nxt  = out_frac_r;
    out_ok_nxt    = out_ok_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          v_nxt     = in_tdata[DW-1:0] & mask_r[DW-1:0];
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!enable_r) begin
          frac_nxt  = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else if (!manual_r) begin
          if (v_r < tmin_r) begin
            tmin_nxt = v_r;
            lo_nxt   = v_r;
          end else begin
            lo_nxt   = tmin_r;
          end
          if (v_r > tmax_r) begin
            tmax_nxt = v_r;
            hi_nxt   = v_r;
          end else begin
            hi_nxt   = tmax_r;
          end
          state_nxt = S_CHECK;
        end else begin
          lo_nxt    = mmin_r[DW-1:0];
          hi_nxt    = mmax_r[DW-1:0];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ok_nxt   = 1'b1;
        rem_nxt  = {1'b0, v_r - lo_r};
        den_nxt  = hi_r - lo_r;
        q_nxt    = '0;
        cnt_nxt  = '0;
        if (hi_r <= lo_r) begin
          frac_nxt  = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end else if (v_r <= lo_r) begin
          frac_nxt  = '0;
          state_nxt = S_DONE;
        end else if (v_r >= hi_r) begin
          frac_nxt  = ONE_Q16;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!diff[DW]) begin
          rem_nxt = diff;
          q_nxt   = {q_r[Q_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[Q_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          frac_nxt  = {1'b0, q_nxt};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_frac_nxt  = (invert_r && ok_r) ? (ONE_Q16 - frac_r) : frac_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       enable_nxt = cfg_wdata[0];
        REG_INVERT:       invert_nxt = cfg_wdata[0];
        REG_MANUAL_RANGE: manual_nxt = cfg_wdata[0];
        REG_MASK_BITS:    mask_nxt   = cfg_wdata;
        REG_MANUAL_MIN:   mmin_nxt   = cfg_wdata;
        REG_MANUAL_MAX:   mmax_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end
    if (cfg_hit) begin
      tmin_nxt = mask_nxt[DW-1:0];
      tmax_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      invert_r    <= 1'b0;
      manual_r    <= 1'b0;
      mask_r      <= MASK_RESET;
      mmin_r      <= '0;
      mmax_r      <= MANUAL_MAX_RESET;
      tmin_r      <= MASK_RESET[DW-1:0];
      tmax_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      invert_r    <= invert_nxt;
      manual_r    <= manual_nxt;
      mask_r      <= mask_nxt;
      mmin_r      <= mmin_nxt;
      mmax_r      <= mmax_nxt;
      tmin_r      <= tmin_nxt;
      tmax_r      <= tmax_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    frac_r     <= frac_nxt;
    ok_r       <= ok_nxt;
    out_frac_r <= out_frac_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a transaction was in progress");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_frac_r <= ONE_Q16))
    else $error("fraction exceeds one");

  a_bad_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_ok_r) |-> (out_frac_r == '0))
    else $error("nonzero fraction without a valid range");

  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (tmax_r == '0))
    else $error("tracked range not reloaded by a register write");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && state_nxt == S_DIV) |=> (cnt_r == 4'd0))
    else $error("divider step count not cleared at start");

endmodule
